[src/tlbp_pkg.sv]
// Package for the two-level branch predictor: sequencer states, command and register codes.
`default_nettype none

package tlbp_pkg;

	// Sequencer states of the predictor core.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_WB,
		ST_SWEEP
	} state_t;

	// Item commands.
	localparam logic CMD_PREDICT = 1'b0;
	localparam logic CMD_UPDATE  = 1'b1;

	// Configuration register indexes.
	localparam logic [2:0] REG_INDEX_BITS    = 3'd0;
	localparam logic [2:0] REG_HISTORY_LEN   = 3'd1;
	localparam logic [2:0] REG_TAG_BITS      = 3'd2;
	localparam logic [2:0] REG_INIT_COUNTER  = 3'd3;
	localparam logic [2:0] REG_GLOBAL_HIST   = 3'd4;
	localparam logic [2:0] REG_GLOBAL_TABLE  = 3'd5;
	localparam logic [2:0] REG_SHARE_MODE    = 3'd6;
	localparam logic [2:0] REG_NONE          = 3'd7;

	// Shared table index selection.
	localparam logic [1:0] SHARE_HIST = 2'd0;
	localparam logic [1:0] SHARE_PC2  = 2'd1;
	localparam logic [1:0] SHARE_PC16 = 2'd2;

endpackage

`default_nettype wire

[src/two_level_branch_predictor_btb_core.sv]
// Each item passes the BTB read on acceptance, the counter read in lookup and the
// write-back, which waits while a stalled result beat is held; a new item is taken
// only in idle, once the last one is done. An update that allocates an entry with
// per-entry counters adds a row refill, one counter a cycle through the counter memory
// write port. Reset clears control, valid bits, histories and counts; the shared table
// reads as the initial counter until written; there is no clearing pass.
`default_nettype none

module two_level_branch_predictor_btb_core #(
	parameter int BTB_DEPTH    = 32,
	parameter int MAX_HISTORY  = 8,
	parameter int MAX_TAG_BITS = 30
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic        cmd,
	input  wire logic [31:0] branch_pc,
	input  wire logic [31:0] actual_target,
	input  wire logic        actual_taken,
	input  wire logic [31:0] earlier_prediction,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic             predict_taken,
	output logic      [31:0] next_fetch,
	output logic             flush,
	output logic      [31:0] branch_count,
	output logic      [31:0] flush_count
);
	import tlbp_pkg::*;

	localparam int IW      = (BTB_DEPTH > 1) ? $clog2(BTB_DEPTH) : 1;
	localparam int MAX_IB  = $clog2(BTB_DEPTH + 1) - 1;
	localparam int HW      = MAX_HISTORY;
	localparam int ROW_LEN = 1 << HW;
	localparam int TW      = MAX_TAG_BITS;
	localparam int LDEPTH  = BTB_DEPTH * ROW_LEN;

	// Configuration registers.
	logic [2:0] ib_q;
	logic [3:0] hl_q;
	logic [4:0] tb_q;
	logic [1:0] init_q;
	logic       ghm_q;
	logic       gtm_q;
	logic [1:0] sm_q;

	// Control and state registers.
	state_t          state_q, state_d;
	logic [BTB_DEPTH-1:0] valid_q;
	logic [HW-1:0]   lh_q [BTB_DEPTH];
	logic [HW-1:0]   gh_q;
	logic [ROW_LEN-1:0] shv_q;
	logic [31:0]     upd_cnt_q;
	logic [31:0]     fl_cnt_q;
	logic [HW-1:0]   sw_q;

	// Item registers.
	logic            cmd_q;
	logic [31:0]     pc_q;
	logic [31:0]     tgt_q;
	logic            tkn_q;
	logic [31:0]     earl_q;
	logic [IW-1:0]   idx_q;
	logic [TW-1:0]   tag_q;
	logic            hit_q;
	logic [HW-1:0]   hist_q;
	logic [HW-1:0]   caddr_q;
	logic [1:0]      newctr_q;

	// Memories and their registered read data.
	logic [TW-1:0]   tag_mem [BTB_DEPTH];
	logic [31:0]     tgt_mem [BTB_DEPTH];
	logic [1:0]      lc_mem  [LDEPTH];
	logic [1:0]      sh_mem  [ROW_LEN];
	logic [TW-1:0]   tag_rd_q;
	logic [31:0]     tgt_rd_q;
	logic [1:0]      lc_rd_q;
	logic [1:0]      sh_rd_q;

	// Output register.
	logic            rsp_valid_q;
	logic            pt_q;
	logic [31:0]     nf_q;
	logic            fl_q;

	logic            cfg_wr;
	logic [2:0]      cfg_idx;
	logic            req_acc;
	logic            out_free;
	logic            fire;
	logic [2:0]      eff_ib;
	logic [IW-1:0]   idx_mask;
	logic [HW-1:0]   hmask;
	logic [TW-1:0]   tmask;
	logic [IW-1:0]   idx_in;
	logic [31:0]     pc_sh;
	logic [TW-1:0]   tag_l;
	logic            hit_l;
	logic [HW-1:0]   hist_l;
	logic [HW-1:0]   pcsel;
	logic [HW-1:0]   caddr_l;
	logic [1:0]      ctr_old;
	logic [1:0]      ctr_new;
	logic [HW-1:0]   nh;
	logic [31:0]     fall;
	logic            fl;
	logic            pt;
	logic            need_sweep;
	logic            sweep_done;

	// APB access decode.
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (cfg_idx)
			REG_INDEX_BITS:   prdata = {29'd0, ib_q};
			REG_HISTORY_LEN:  prdata = {28'd0, hl_q};
			REG_TAG_BITS:     prdata = {27'd0, tb_q};
			REG_INIT_COUNTER: prdata = {30'd0, init_q};
			REG_GLOBAL_HIST:  prdata = {31'd0, ghm_q};
			REG_GLOBAL_TABLE: prdata = {31'd0, gtm_q};
			REG_SHARE_MODE:   prdata = {30'd0, sm_q};
			default:          prdata = 32'd0;
		endcase
	end

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ib_q   <= 3'd0;
			hl_q   <= 4'd1;
			tb_q   <= 5'd0;
			init_q <= 2'd1;
			ghm_q  <= 1'b0;
			gtm_q  <= 1'b0;
			sm_q   <= SHARE_HIST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_INDEX_BITS:   ib_q   <= pwdata[2:0];
				REG_HISTORY_LEN:  hl_q   <= pwdata[3:0];
				REG_TAG_BITS:     tb_q   <= pwdata[4:0];
				REG_INIT_COUNTER: init_q <= pwdata[1:0];
				REG_GLOBAL_HIST:  ghm_q  <= pwdata[0];
				REG_GLOBAL_TABLE: gtm_q  <= pwdata[0];
				REG_SHARE_MODE:   sm_q   <= pwdata[1:0];
				default:          ;
			endcase
		end
	end

	// Field masks derived from the configuration.
	always_comb begin
		eff_ib = (int'(ib_q) > MAX_IB) ? 3'(MAX_IB) : ib_q;
		for (int j = 0; j < IW; j++) begin
			idx_mask[j] = (j < int'(eff_ib));
		end
		for (int j = 0; j < HW; j++) begin
			hmask[j] = (j < int'(hl_q)) || (j == 0);
		end
		for (int j = 0; j < TW; j++) begin
			tmask[j] = (j < int'(tb_q));
		end
	end

	assign idx_in = branch_pc[2 +: IW] & idx_mask;

	// Lookup stage: tag compare, history choice and counter address.
	always_comb begin
		pc_sh   = pc_q >> ({1'b0, eff_ib} + 4'd2);
		tag_l   = pc_sh[TW-1:0] & tmask;
		hit_l   = valid_q[idx_q] && (tag_rd_q == tag_l);
		if (ghm_q) begin
			hist_l = gh_q;
		end else if (cmd_q == CMD_UPDATE && !hit_l) begin
			hist_l = '0;
		end else begin
			hist_l = lh_q[idx_q];
		end
		priority if (!gtm_q) begin
			pcsel = '0;
		end else if (sm_q == SHARE_PC2) begin
			pcsel = pc_q[2 +: HW];
		end else if (sm_q == SHARE_PC16) begin
			pcsel = pc_q[16 +: HW];
		end else begin
			pcsel = '0;
		end
		caddr_l = (hist_l ^ pcsel) & hmask;
	end

	// Write-back stage: counter training, next history and flush decision.
	always_comb begin
		if (gtm_q) begin
			ctr_old = shv_q[caddr_q] ? sh_rd_q : init_q;
		end else begin
			ctr_old = hit_q ? lc_rd_q : init_q;
		end
		pt = hit_q && ctr_old[1];
		if (tkn_q) begin
			ctr_new = (ctr_old == 2'd3) ? ctr_old : ctr_old + 2'd1;
		end else begin
			ctr_new = (ctr_old == 2'd0) ? ctr_old : ctr_old - 2'd1;
		end
		nh   = HW'({hist_q, tkn_q}) & hmask;
		fall = pc_q + 32'd4;
		fl   = tkn_q ? (earl_q != tgt_q) : (earl_q != fall);
	end

	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign fire       = (state_q == ST_WB) && out_free;
	assign req_acc    = req_valid && !req_stall;
	assign need_sweep = (cmd_q == CMD_UPDATE) && !hit_q && !gtm_q;
	assign sweep_done = (sw_q == {HW{1'b1}});

	// Sequencer next state.
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				state_d = ST_WB;
			end
			ST_WB: begin
				if (fire) state_d = need_sweep ? ST_SWEEP : ST_IDLE;
			end
			ST_SWEEP: begin
				if (sweep_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Item capture and lookup pipeline registers.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_q  <= cmd;
			pc_q   <= branch_pc;
			tgt_q  <= actual_target;
			tkn_q  <= actual_taken;
			earl_q <= earlier_prediction;
			idx_q  <= idx_in;
		end
		if (state_q == ST_LOOKUP) begin
			tag_q   <= tag_l;
			hit_q   <= hit_l;
			hist_q  <= hist_l;
			caddr_q <= caddr_l;
		end
		if (fire) begin
			newctr_q <= ctr_new;
		end
	end

	// BTB tag and target memories.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			tag_rd_q <= tag_mem[idx_in];
			tgt_rd_q <= tgt_mem[idx_in];
		end
		if (fire && cmd_q == CMD_UPDATE) begin
			tag_mem[idx_q] <= tag_q;
			tgt_mem[idx_q] <= tgt_q;
		end
	end

	// Per-entry counter memory: trained in write-back, row refilled on allocation.
	always_ff @(posedge clk) begin
		if (state_q == ST_LOOKUP) begin
			lc_rd_q <= lc_mem[{idx_q, caddr_l}];
		end
		if (fire && cmd_q == CMD_UPDATE && !gtm_q && hit_q) begin
			lc_mem[{idx_q, caddr_q}] <= ctr_new;
		end else if (state_q == ST_SWEEP) begin
			lc_mem[{idx_q, sw_q}] <= (sw_q == caddr_q) ? newctr_q : init_q;
		end
	end

	// Shared counter memory.
	always_ff @(posedge clk) begin
		if (state_q == ST_LOOKUP) begin
			sh_rd_q <= sh_mem[caddr_l];
		end
		if (fire && cmd_q == CMD_UPDATE && gtm_q) begin
			sh_mem[caddr_q] <= ctr_new;
		end
	end

	// Valid bits, histories, shared-table written marks, counts and sweep position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			gh_q      <= '0;
			shv_q     <= '0;
			upd_cnt_q <= 32'd0;
			fl_cnt_q  <= 32'd0;
			sw_q      <= '0;
			for (int i = 0; i < BTB_DEPTH; i++) begin
				lh_q[i] <= '0;
			end
		end else begin
			if (cfg_wr && cfg_idx != REG_NONE) begin
				shv_q <= '0;
			end
			if (state_q == ST_SWEEP) begin
				sw_q <= sw_q + {{(HW-1){1'b0}}, 1'b1};
			end
			if (fire && cmd_q == CMD_UPDATE) begin
				valid_q[idx_q] <= 1'b1;
				upd_cnt_q      <= upd_cnt_q + 32'd1;
				fl_cnt_q       <= fl_cnt_q + {31'd0, fl};
				sw_q           <= '0;
				if (ghm_q) begin
					gh_q <= nh;
				end else begin
					lh_q[idx_q] <= nh;
				end
				if (gtm_q) begin
					shv_q[caddr_q] <= 1'b1;
				end
			end
		end
	end

	// Result beat register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (cmd_q == CMD_PREDICT) begin
				pt_q <= pt;
				nf_q <= pt ? tgt_rd_q : fall;
				fl_q <= 1'b0;
			end else begin
				pt_q <= 1'b0;
				nf_q <= 32'd0;
				fl_q <= fl;
			end
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign predict_taken = pt_q;
	assign next_fetch    = nf_q;
	assign flush         = fl_q;
	assign branch_count  = upd_cnt_q;
	assign flush_count   = fl_cnt_q;

	// An accepted item always moves on to the lookup stage.
	a_accept_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> state_q == ST_LOOKUP)
		else $error("accepted item did not enter lookup");

	// A result beat only appears out of write-back.
	a_rsp_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_WB)
		else $error("result beat without write-back");

	// Counts only move when an item is written back.
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(upd_cnt_q) && $stable(fl_cnt_q))
		else $error("counts changed outside write-back");

	// The row refill only follows write-back or itself.
	a_sweep_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> $past(state_q) == ST_WB || $past(state_q) == ST_SWEEP)
		else $error("row refill entered unexpectedly");

endmodule

`default_nettype wire
